// ===== hw/rtl/umfa_pkg.sv =====
// ----------------------------------------------------------------------------
// umfa_pkg
// Shared types and constants for the mjpeg frame assembler.
// ----------------------------------------------------------------------------
package umfa_pkg;

    localparam int FRAME_BYTES   = 262144;
    localparam int MAX_PACKET    = 2048;
    localparam int LEN_W         = 12;
    localparam int ALEN_W        = 19;
    localparam int ADDR_W        = 18;
    localparam int MAX_RESULTS   = 3;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

    localparam logic [7:0]  INFO_ERR_MASK = 8'h40;
    localparam logic [7:0]  SOI_FIRST     = 8'hff;
    localparam logic [7:0]  SOI_SECOND    = 8'hd8;
    localparam logic [15:0] EOI_MARK      = 16'hffd9;

    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_OVERFLOW = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic [7:0]       packet_byte;
        logic             first_of_packet;
        logic [LEN_W-1:0] packet_length;
    } in_item_t;

    typedef struct packed {
        result_kind_t      result_kind;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic [ALEN_W-1:0] frame_length;
        logic              frame_id;
        logic              last;
    } result_t;

endpackage

// ===== hw/rtl/umfa_core.sv =====
// ----------------------------------------------------------------------------
// umfa_core
// Packet header parsing and frame tracking; produces up to three results
// for one packet byte in a single pass.
// ----------------------------------------------------------------------------
module umfa_core
    import umfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  in_item_t              item,
    output result_t [MAX_RESULTS-1:0] res,
    output logic [1:0]            res_count
);

    typedef enum logic [1:0] {
        MODE_DISCARD = 2'd0,
        MODE_INFO    = 2'd1,
        MODE_ACTIVE  = 2'd2
    } mode_t;

    logic              capturing_reg, capturing_next;
    logic              have_prev_reg, have_prev_next;
    logic              prev_id_reg, prev_id_next;
    logic              cur_id_reg, cur_id_next;
    logic              data_seen_reg, data_seen_next;
    logic [ALEN_W-1:0] alen_reg, alen_next;
    logic [LEN_W-1:0]  byte_index_reg, byte_index_next;
    logic [7:0]        hdr_len_reg, hdr_len_next;
    mode_t             mode_reg, mode_next;
    logic              pkt_id_reg, pkt_id_next;
    logic              pkt_end_reg, pkt_end_next;
    logic [7:0]        held_reg, held_next;
    logic [15:0]       tail_reg, tail_next;

    always_comb begin
        logic [7:0]        b;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  idx;
        logic [LEN_W-1:0]  pay;
        logic [ALEN_W:0]   room_sum;
        logic              id;
        logic              done;
        logic [1:0]        n;

        b   = item.packet_byte;
        len = item.packet_length;
        idx = '0;
        pay = '0;
        room_sum = '0;
        id  = 1'b0;
        done = 1'b0;
        n   = 2'd0;
        res = '0;

        capturing_next  = capturing_reg;
        have_prev_next  = have_prev_reg;
        prev_id_next    = prev_id_reg;
        cur_id_next     = cur_id_reg;
        data_seen_next  = data_seen_reg;
        alen_next       = alen_reg;
        byte_index_next = byte_index_reg;
        hdr_len_next    = hdr_len_reg;
        mode_next       = mode_reg;
        pkt_id_next     = pkt_id_reg;
        pkt_end_next    = pkt_end_reg;
        held_next       = held_reg;
        tail_next       = tail_reg;

        if (item.first_of_packet) begin
            byte_index_next = '0;
            mode_next = MODE_DISCARD;
            if (len >= LEN_W'(2) && len <= LEN_W'(MAX_PACKET) && b >= 8'd2
                && {4'd0, b} <= len) begin
                hdr_len_next = b;
                mode_next = MODE_INFO;
            end
        end else begin
            if (byte_index_reg != {LEN_W{1'b1}}) begin
                byte_index_next = byte_index_reg + LEN_W'(1);
            end
            idx = byte_index_next;
            if (mode_reg == MODE_DISCARD) begin
                done = 1'b1;
            end else if (idx >= len || len > LEN_W'(MAX_PACKET)
                         || {4'd0, hdr_len_reg} > len) begin
                mode_next = MODE_DISCARD;
                done = 1'b1;
            end
            pay = len - {4'd0, hdr_len_reg};

            if (!done && mode_reg == MODE_INFO) begin
                id = b[0];
                pkt_id_next  = id;
                pkt_end_next = b[1];
                mode_next    = MODE_DISCARD;
                if ((b & INFO_ERR_MASK) != 8'd0) begin
                    capturing_next = 1'b0;
                    data_seen_next = 1'b0;
                    alen_next      = '0;
                    have_prev_next = 1'b1;
                    prev_id_next   = id;
                    done = 1'b1;
                end
                if (!done && !capturing_next) begin
                    if (!have_prev_next) begin
                        have_prev_next = 1'b1;
                        prev_id_next   = id;
                        done = 1'b1;
                    end else if (prev_id_next == id) begin
                        done = 1'b1;
                    end else begin
                        capturing_next = 1'b1;
                        cur_id_next    = id;
                        data_seen_next = 1'b0;
                    end
                end
                if (!done && id != cur_id_next) begin
                    if (data_seen_next && alen_next >= ALEN_W'(2)
                        && tail_next == EOI_MARK) begin
                        res[n].result_kind  = KIND_COMPLETE;
                        res[n].frame_length = alen_next;
                        res[n].frame_id     = cur_id_next;
                        n = n + 2'd1;
                        capturing_next = 1'b0;
                        data_seen_next = 1'b0;
                        alen_next      = '0;
                        have_prev_next = 1'b1;
                        prev_id_next   = cur_id_next;
                        done = 1'b1;
                    end else begin
                        alen_next      = '0;
                        capturing_next = 1'b1;
                        cur_id_next    = id;
                        data_seen_next = 1'b0;
                    end
                end
                room_sum = {1'b0, alen_next} + (ALEN_W+1)'(pay);
                if (!done && pay != '0) begin
                    if (!data_seen_next) begin
                        if (pay < LEN_W'(2)) begin
                            done = 1'b1;
                        end
                    end else if (room_sum > (ALEN_W+1)'(FRAME_BYTES)) begin
                        res[n].result_kind = KIND_OVERFLOW;
                        n = n + 2'd1;
                        capturing_next = 1'b0;
                        data_seen_next = 1'b0;
                        alen_next      = '0;
                        have_prev_next = 1'b1;
                        prev_id_next   = id;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    mode_next = MODE_ACTIVE;
                end
            end else if (!done && idx >= {4'd0, hdr_len_reg}) begin
                if (data_seen_next) begin
                    res[n].result_kind   = KIND_WRITE;
                    res[n].write_address = alen_next[ADDR_W-1:0];
                    res[n].write_data    = b;
                    n = n + 2'd1;
                    alen_next = alen_next + ALEN_W'(1);
                    tail_next = {tail_next[7:0], b};
                end else if (idx == {4'd0, hdr_len_reg}) begin
                    held_next = b;
                end else if (held_next == SOI_FIRST && b == SOI_SECOND) begin
                    res[n].result_kind   = KIND_WRITE;
                    res[n].write_address = alen_next[ADDR_W-1:0];
                    res[n].write_data    = held_next;
                    n = n + 2'd1;
                    alen_next = alen_next + ALEN_W'(1);
                    res[n].result_kind   = KIND_WRITE;
                    res[n].write_address = alen_next[ADDR_W-1:0];
                    res[n].write_data    = b;
                    n = n + 2'd1;
                    alen_next = alen_next + ALEN_W'(1);
                    tail_next = {held_next, b};
                    data_seen_next = 1'b1;
                end else begin
                    mode_next = MODE_DISCARD;
                    done = 1'b1;
                end
            end

            if (!done && idx == len - LEN_W'(1)) begin
                mode_next = MODE_DISCARD;
                if (pkt_end_next) begin
                    if (data_seen_next && alen_next >= ALEN_W'(2)
                        && tail_next == EOI_MARK) begin
                        res[n].result_kind  = KIND_COMPLETE;
                        res[n].frame_length = alen_next;
                        res[n].frame_id     = cur_id_next;
                        n = n + 2'd1;
                        prev_id_next = cur_id_next;
                    end else begin
                        prev_id_next = pkt_id_next;
                    end
                    capturing_next = 1'b0;
                    data_seen_next = 1'b0;
                    alen_next      = '0;
                    have_prev_next = 1'b1;
                end
            end
        end

        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k].last = (2'(k) + 2'd1 == n);
        end
        res_count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            prev_id_reg    <= 1'b0;
            cur_id_reg     <= 1'b0;
            data_seen_reg  <= 1'b0;
            alen_reg       <= '0;
            byte_index_reg <= '0;
            hdr_len_reg    <= '0;
            mode_reg       <= MODE_DISCARD;
            pkt_id_reg     <= 1'b0;
            pkt_end_reg    <= 1'b0;
            held_reg       <= '0;
            tail_reg       <= '0;
        end else if (fire) begin
            capturing_reg  <= capturing_next;
            have_prev_reg  <= have_prev_next;
            prev_id_reg    <= prev_id_next;
            cur_id_reg     <= cur_id_next;
            data_seen_reg  <= data_seen_next;
            alen_reg       <= alen_next;
            byte_index_reg <= byte_index_next;
            hdr_len_reg    <= hdr_len_next;
            mode_reg       <= mode_next;
            pkt_id_reg     <= pkt_id_next;
            pkt_end_reg    <= pkt_end_next;
            held_reg       <= held_next;
            tail_reg       <= tail_next;
        end
    end

endmodule

// ===== hw/rtl/umfa_out_fifo.sv =====
// ----------------------------------------------------------------------------
// umfa_out_fifo
// Result queue: takes up to three results per cycle, hands out one.
// ----------------------------------------------------------------------------
module umfa_out_fifo
    import umfa_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  result_t [MAX_RESULTS-1:0] push_data,
    input  logic [1:0]                push_count,
    output logic                      room,
    output logic                      out_valid,
    input  logic                      out_ready,
    output result_t                   out_data
);

    localparam int CNT_W = FIFO_PTR_W + 1;

    result_t [FIFO_DEPTH-1:0] mem_reg;
    logic [FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [1:0]               n_in;
    logic                     pop;

    assign n_in      = push ? push_count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_in);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + CNT_W'(n_in) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < n_in) begin
                mem_reg[wr_ptr_reg + FIFO_PTR_W'(k)] <= push_data[k];
            end
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/uvc_mjpeg_frame_assembler.sv =====
// ----------------------------------------------------------------------------
// uvc_mjpeg_frame_assembler
// Assembles mjpeg frames from uvc payload packets, one byte per cycle while the result queue has room.
//
// s_ channel: one packet byte per word, s_tuser marks the first byte of a
// packet, the packet length rides on every word. m_ channel: one result per
// word, kind in m_tuser (frame byte write, frame complete, overflow), m_tlast
// on the final result caused by one input byte.
// A byte is taken into an input register, parsed in one pass and its zero to
// three results go into an eight-entry result queue that feeds m_. One byte
// is accepted every cycle while the queue has room for three results;
// the sustained rate is one byte per cycle, limited only by the
// one-result-per-cycle output port when a byte yields several results.
// Reset clears all frame state and empties the queue; capture begins only
// after a frame-id toggle. If the receiver stalls, the queue fills and
// s_tready drops; no result is lost.
// ----------------------------------------------------------------------------
module uvc_mjpeg_frame_assembler
    import umfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // packet_byte, packet_length, zero pad
    input  logic        s_tuser,   // first_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // write_address, write_data, frame_length, frame_id, zero pad
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    logic                      in_valid_reg;
    in_item_t                  in_item_reg;
    logic                      consume;
    logic                      room;
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                res_count;
    result_t                   out_data;

    assign consume  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.packet_byte     <= s_tdata[7:0];
            in_item_reg.packet_length   <= s_tdata[19:8];
            in_item_reg.first_of_packet <= s_tuser;
        end
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    umfa_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (consume),
        .item      (in_item_reg),
        .res       (res),
        .res_count (res_count)
    );

    umfa_out_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (consume),
        .push_data  (res),
        .push_count (res_count),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {2'b00, out_data.frame_id, out_data.frame_length,
                      out_data.write_data, out_data.write_address};
    assign m_tuser = out_data.result_kind;
    assign m_tlast = out_data.last;

endmodule
